>>> rtl/ktl_pkg.sv
package ktl_pkg;

  localparam int unsigned TOK_LEN_BITS = 16;
  localparam int unsigned TOK_START_BITS = 16;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_NUM   = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    TOK_IDENT  = 4'd0,
    TOK_LET    = 4'd1,
    TOK_INT    = 4'd2,
    TOK_FLOAT  = 4'd3,
    TOK_NUMBER = 4'd4,
    TOK_EQUALS = 4'd5,
    TOK_COLON  = 4'd6,
    TOK_SEMI   = 4'd7,
    TOK_EOF    = 4'd8
  } tok_type_t;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;

  localparam logic [2:0] KW_ALL = 3'b111;

  typedef struct packed {
    logic [3:0]                  tok_type;
    logic [TOK_START_BITS-1:0]   tok_start;
    logic [TOK_LEN_BITS-1:0]     tok_len;
    logic                        last;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0d) || c == 8'h20;
  endfunction

  // bit0 "let", bit1 "int", bit2 "float"
  function automatic logic [2:0] kw_update(input logic [2:0] hits,
                                           input logic [TOK_LEN_BITS-1:0] idx,
                                           input logic [7:0] c);
    logic m_let;
    logic m_int;
    logic m_float;
    m_let = (idx == 16'd0 && c == 8'h6c) || (idx == 16'd1 && c == 8'h65) ||
            (idx == 16'd2 && c == 8'h74);
    m_int = (idx == 16'd0 && c == 8'h69) || (idx == 16'd1 && c == 8'h6e) ||
            (idx == 16'd2 && c == 8'h74);
    m_float = (idx == 16'd0 && c == 8'h66) || (idx == 16'd1 && c == 8'h6c) ||
              (idx == 16'd2 && c == 8'h6f) || (idx == 16'd3 && c == 8'h61) ||
              (idx == 16'd4 && c == 8'h74);
    return hits & {m_float, m_int, m_let};
  endfunction

  function automatic logic [3:0] ident_type(input logic [2:0] hits,
                                            input logic [TOK_LEN_BITS-1:0] len);
    logic [3:0] t;
    t = TOK_IDENT;
    if (hits[0] && len == 16'd3) begin
      t = TOK_LET;
    end else if (hits[1] && len == 16'd3) begin
      t = TOK_INT;
    end else if (hits[2] && len == 16'd5) begin
      t = TOK_FLOAT;
    end
    return t;
  endfunction

endpackage

>>> rtl/ktl_src_if.sv
interface ktl_src_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink (input valid, input func, input ch, output ready);
endinterface

>>> rtl/ktl_tok_if.sv
interface ktl_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  tok_type;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic        last;

  modport source (output valid, output tok_type, output tok_start, output tok_len,
                  output last, input ready);
  modport sink (input valid, input tok_type, input tok_start, input tok_len,
                input last, output ready);
endinterface

>>> rtl/ktl_tok_queue.sv
module ktl_tok_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_n,
  input  ktl_pkg::tok_t push0,
  input  ktl_pkg::tok_t push1,
  output logic          room2,
  ktl_tok_if.source     tok_ch
);
  import ktl_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW = $clog2(DEPTH);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic [AW:0]   count_next;
  logic          pop;

  assign pop = tok_ch.valid && tok_ch.ready;
  assign room2 = count <= (AW+1)'(DEPTH - 2);
  assign count_next = count + {{(AW-1){1'b0}}, push_n} - {{AW{1'b0}}, pop};

  assign tok_ch.valid     = count != '0;
  assign tok_ch.tok_type  = mem[rd_ptr].tok_type;
  assign tok_ch.tok_start = mem[rd_ptr].tok_start;
  assign tok_ch.tok_len   = mem[rd_ptr].tok_len;
  assign tok_ch.last      = mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

endmodule

>>> rtl/keyword_token_lexer.sv
// A token is written into the token queue when the byte that ends it is taken.
// Throughput: one byte per cycle; the input holds only while the four-entry
// token queue has more than two words waiting, which happens when tokens come
// faster than the sink takes them.
// Reset: rst (synchronous) clears scan state, offset and the token queue.
module keyword_token_lexer #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ktl_src_if.sink   src_ch,
  ktl_tok_if.source tok_ch
);
  import ktl_pkg::*;

  mode_t                    mode;
  mode_t                    mode_next;
  logic [POS_BITS-1:0]      position;
  logic [POS_BITS-1:0]      position_next;
  logic [POS_BITS-1:0]      token_start;
  logic [POS_BITS-1:0]      token_start_next;
  logic [TOK_LEN_BITS-1:0]  token_length;
  logic [TOK_LEN_BITS-1:0]  token_length_next;
  logic [2:0]               keyword_hits;
  logic [2:0]               keyword_hits_next;

  logic                     accept;
  logic                     room2;
  logic [7:0]               c;
  logic [TOK_LEN_BITS-1:0]  len_inc;
  tok_t                     pend_tok;
  tok_t                     byte_tok;
  logic                     pend_v;
  logic                     byte_v;
  tok_t                     push0;
  tok_t                     push1;
  logic [1:0]               push_n;

  assign src_ch.ready = room2;
  assign accept = src_ch.valid && src_ch.ready;
  assign c = src_ch.ch;
  assign len_inc = (token_length == '1) ? token_length : token_length + 16'd1;

  always_comb begin
    pend_tok.tok_type  = (mode == MODE_IDENT) ? ident_type(keyword_hits, token_length)
                                              : TOK_NUMBER;
    pend_tok.tok_start = TOK_START_BITS'(token_start);
    pend_tok.tok_len   = token_length;
    pend_tok.last      = 1'b0;
  end

  always_comb begin
    mode_next         = mode;
    position_next     = position;
    token_start_next  = token_start;
    token_length_next = token_length;
    keyword_hits_next = keyword_hits;
    pend_v            = 1'b0;
    byte_v            = 1'b0;
    byte_tok.tok_type  = TOK_EOF;
    byte_tok.tok_start = TOK_START_BITS'(position);
    byte_tok.tok_len   = '0;
    byte_tok.last      = 1'b1;

    if (src_ch.func == FUNC_END) begin
      if (mode != MODE_DONE) begin
        pend_v = (mode == MODE_IDENT) || (mode == MODE_NUM);
        byte_v = 1'b1;
      end
      mode_next         = MODE_IDLE;
      position_next     = '0;
      token_start_next  = '0;
      token_length_next = '0;
      keyword_hits_next = KW_ALL;
    end else if (mode != MODE_DONE) begin
      if (mode == MODE_IDENT && (is_alpha(c) || is_digit(c))) begin
        keyword_hits_next = kw_update(keyword_hits, token_length, c);
        token_length_next = len_inc;
      end else if (mode == MODE_NUM && is_digit(c)) begin
        token_length_next = len_inc;
      end else begin
        pend_v    = (mode == MODE_IDENT) || (mode == MODE_NUM);
        mode_next = MODE_IDLE;
        if (c == CH_NUL) begin
          byte_v    = 1'b1;
          mode_next = MODE_DONE;
        end else if (is_space(c)) begin
          byte_v = 1'b0;
        end else if (is_alpha(c)) begin
          mode_next         = MODE_IDENT;
          token_start_next  = position;
          token_length_next = 16'd1;
          keyword_hits_next = kw_update(KW_ALL, 16'd0, c);
        end else if (is_digit(c)) begin
          mode_next         = MODE_NUM;
          token_start_next  = position;
          token_length_next = 16'd1;
        end else if (c == CH_EQUALS) begin
          byte_v            = 1'b1;
          byte_tok.tok_type = TOK_EQUALS;
          byte_tok.tok_len  = 16'd1;
        end else if (c == CH_COLON) begin
          byte_v            = 1'b1;
          byte_tok.tok_type = TOK_COLON;
          byte_tok.tok_len  = 16'd1;
        end else if (c == CH_SEMI) begin
          byte_v            = 1'b1;
          byte_tok.tok_type = TOK_SEMI;
          byte_tok.tok_len  = 16'd1;
        end
      end
      if (mode_next != MODE_DONE) begin
        position_next = position + POS_BITS'(1);
      end
    end
  end

  always_comb begin
    push0      = pend_v ? pend_tok : byte_tok;
    push0.last = !(pend_v && byte_v);
    push1      = byte_tok;
    push_n     = accept ? ({1'b0, pend_v} + {1'b0, byte_v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      position     <= '0;
      token_start  <= '0;
      token_length <= '0;
      keyword_hits <= KW_ALL;
    end else if (accept) begin
      mode         <= mode_next;
      position     <= position_next;
      token_start  <= token_start_next;
      token_length <= token_length_next;
      keyword_hits <= keyword_hits_next;
    end
  end

  ktl_tok_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .push0  (push0),
    .push1  (push1),
    .room2  (room2),
    .tok_ch (tok_ch)
  );

endmodule

>>> dv/token_stream_checker.sv
module token_stream_checker #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  ktl_src_if   src_ch,
  ktl_tok_if   tok_ch,
  output int   fails,
  output int   waiting
);
  import ktl_pkg::*;

  typedef struct {
    tok_type_t   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } lex_token_t;

  lex_token_t pending_tokens[$];

  mode_t               mode;
  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] tok_from;
  logic [15:0]         tok_len;
  logic [2:0]          kw_live;
  int                  bad;

  function automatic logic [2:0] kw_filter(input logic [2:0] hits, input logic [15:0] idx,
                                           input logic [7:0] c);
    logic [39:0] word;
    int          n;
    for (int k = 0; k < 3; k++) begin
      word = (k == 2) ? "float" : ((k == 1) ? "int" : "let");
      n = (k == 2) ? 5 : 3;
      if (int'(idx) >= n || word[8*(n-1-int'(idx)) +: 8] != c) begin
        hits[k] = 1'b0;
      end
    end
    return hits;
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return c inside {["A":"Z"], ["a":"z"]};
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  task automatic push_token(input tok_type_t kind, input logic [POS_BITS-1:0] start,
                            input logic [15:0] len);
    lex_token_t t;
    t.kind = kind;
    t.start = 16'(start);
    t.len = len;
    t.last = 1'b0;
    pending_tokens.insert(pending_tokens.size(), t);
  endtask

  task automatic close_token();
    tok_type_t kind;
    if (mode == MODE_IDENT) begin
      kind = TOK_IDENT;
      if (kw_live[0] && tok_len == 16'd3) begin
        kind = TOK_LET;
      end else if (kw_live[1] && tok_len == 16'd3) begin
        kind = TOK_INT;
      end else if (kw_live[2] && tok_len == 16'd5) begin
        kind = TOK_FLOAT;
      end
      push_token(kind, tok_from, tok_len);
    end else if (mode == MODE_NUM) begin
      push_token(TOK_NUMBER, tok_from, tok_len);
    end
  endtask

  task automatic clear_scan();
    mode = MODE_IDLE;
    pos = '0;
    tok_from = '0;
    tok_len = '0;
    kw_live = KW_ALL;
  endtask

  task automatic lex_byte(input logic f, input logic [7:0] c);
    int before_n;
    before_n = pending_tokens.size();
    if (f == FUNC_END) begin
      if (mode != MODE_DONE) begin
        close_token();
        push_token(TOK_EOF, pos, 16'd0);
      end
      clear_scan();
    end else if (mode != MODE_DONE) begin
      if (mode == MODE_IDENT && (letter(c) || digit(c))) begin
        kw_live = kw_filter(kw_live, tok_len, c);
        if (tok_len != 16'hffff) begin
          tok_len = tok_len + 16'd1;
        end
      end else if (mode == MODE_NUM && digit(c)) begin
        if (tok_len != 16'hffff) begin
          tok_len = tok_len + 16'd1;
        end
      end else begin
        close_token();
        mode = MODE_IDLE;
        if (c == CH_NUL) begin
          push_token(TOK_EOF, pos, 16'd0);
          mode = MODE_DONE;
        end else if (letter(c)) begin
          mode = MODE_IDENT;
          tok_from = pos;
          tok_len = 16'd1;
          kw_live = kw_filter(KW_ALL, 16'd0, c);
        end else if (digit(c)) begin
          mode = MODE_NUM;
          tok_from = pos;
          tok_len = 16'd1;
        end else if (c == CH_EQUALS) begin
          push_token(TOK_EQUALS, pos, 16'd1);
        end else if (c == CH_COLON) begin
          push_token(TOK_COLON, pos, 16'd1);
        end else if (c == CH_SEMI) begin
          push_token(TOK_SEMI, pos, 16'd1);
        end
      end
      if (mode != MODE_DONE) begin
        pos = pos + 1'b1;
      end
    end
    if (pending_tokens.size() > before_n) begin
      pending_tokens[$].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    lex_token_t want;
    if (rst) begin
      clear_scan();
      pending_tokens.delete();
      bad = 0;
    end else begin
      if (tok_ch.valid && tok_ch.ready) begin
        if (pending_tokens.size() == 0) begin
          if (bad < 10) begin
            $display("%0t unexpected token: type %0d start %0d len %0d last %0b", $time,
                     tok_ch.tok_type, tok_ch.tok_start, tok_ch.tok_len, tok_ch.last);
          end
          bad++;
        end else begin
          want = pending_tokens.pop_front();
          if (tok_ch.tok_type !== want.kind || tok_ch.tok_start !== want.start ||
              tok_ch.tok_len !== want.len || tok_ch.last !== want.last) begin
            if (bad < 10) begin
              $display("%0t token mismatch: exp type %0d start %0d len %0d last %0b", $time,
                       want.kind, want.start, want.len, want.last);
              $display("%0t                 got type %0d start %0d len %0d last %0b", $time,
                       tok_ch.tok_type, tok_ch.tok_start, tok_ch.tok_len, tok_ch.last);
            end
            bad++;
          end
        end
      end
      if (src_ch.valid && src_ch.ready) begin
        lex_byte(src_ch.func, src_ch.ch);
      end
    end
    fails <= bad;
    waiting <= pending_tokens.size();
  end

endmodule

>>> dv/tb_keyword_token_lexer.sv
module tb_keyword_token_lexer;
  import ktl_pkg::*;

  localparam int unsigned POS_BITS = 16;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   waiting;
  int   burst_left;
  int   items;
  logic in_tail;
  int   rx_left;
  rx_mode_t rx_mode;

  string near_miss [10] = '{"le", "lets", "Let", "INT", "in", "int0", "floa", "floats",
                             "flo4t", "l"};

  ktl_src_if src_ch ();
  ktl_tok_if tok_ch ();

  keyword_token_lexer #(.POS_BITS(POS_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .src_ch (src_ch),
    .tok_ch (tok_ch)
  );

  token_stream_checker #(.POS_BITS(POS_BITS)) tok_check (
    .clk     (clk),
    .rst     (rst),
    .src_ch  (src_ch),
    .tok_ch  (tok_ch),
    .fails   (fails),
    .waiting (waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: begin
        tok_ch.ready <= 1'b1;
      end
      RX_COIN: begin
        tok_ch.ready <= 1'($urandom_range(0, 1));
      end
      RX_SPARSE: begin
        tok_ch.ready <= (rx_left % 4 == 0);
      end
      default: begin
        tok_ch.ready <= (rx_left < 4);
      end
    endcase
  end

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? 8'(8'h30 + $urandom_range(0, 9)) : rand_letter();
  endfunction

  task automatic put_word(input logic f, input logic [7:0] c);
    if (burst_left == 0) begin
      src_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    src_ch.valid <= 1'b1;
    src_ch.func <= f;
    src_ch.ch <= c;
    @(posedge clk);
    while (!src_ch.ready) @(posedge clk);
    if (f == FUNC_END) begin
      items++;
      in_tail = 1'b0;
    end else if (!in_tail) begin
      items++;
      in_tail = (c == CH_NUL);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_word(FUNC_BYTE, s[i]);
    end
  endtask

  task automatic send_token();
    logic [7:0] c;
    int         n;
    case ($urandom_range(0, 14))
      0: send_text("let");
      1: send_text("int");
      2: send_text("float");
      3: send_text(near_miss[$urandom_range(0, 9)]);
      4, 5: begin
        put_word(FUNC_BYTE, rand_letter());
        repeat ($urandom_range(0, 7)) put_word(FUNC_BYTE, rand_alnum());
      end
      6: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        repeat (n) put_word(FUNC_BYTE, 8'(8'h30 + $urandom_range(0, 9)));
      end
      7: put_word(FUNC_BYTE, CH_EQUALS);
      8: put_word(FUNC_BYTE, CH_COLON);
      9: put_word(FUNC_BYTE, CH_SEMI);
      10, 11: begin
        repeat ($urandom_range(1, 3)) begin
          n = $urandom_range(0, 5);
          put_word(FUNC_BYTE, (n == 5) ? 8'd32 : 8'(9 + n));
        end
      end
      12: begin
        do c = 8'($urandom_range(1, 255));
        while (c inside {["0":"9"], ["A":"Z"], ["a":"z"], [8'd9:8'd13], 8'd32,
                         CH_EQUALS, CH_COLON, CH_SEMI});
        put_word(FUNC_BYTE, c);
      end
      13: put_word(FUNC_BYTE, 8'($urandom_range(1, 255)));
      default: put_word(FUNC_BYTE, ($urandom_range(0, 5) == 0) ? CH_NUL : 8'd32);
    endcase
  endtask

  initial begin
    rst = 1'b1;
    src_ch.valid = 1'b0;
    src_ch.func = FUNC_BYTE;
    src_ch.ch = 8'h00;
    tok_ch.ready = 1'b0;
    burst_left = 0;
    items = 0;
    in_tail = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("let=int:float;");
    put_word(FUNC_BYTE, 8'hff);
    put_word(FUNC_BYTE, 8'h80);
    put_word(FUNC_BYTE, 8'h09);
    put_word(FUNC_BYTE, 8'h0d);
    put_word(FUNC_BYTE, 8'h20);
    send_text("x");
    put_word(FUNC_BYTE, CH_NUL);
    send_text("a");
    put_word(FUNC_END, 8'hff);
    send_text("9");
    put_word(FUNC_END, 8'h00);

    send_text("floa");
    repeat (65534) put_word(FUNC_BYTE, rand_alnum());
    put_word(FUNC_BYTE, CH_SEMI);
    repeat (65537) put_word(FUNC_BYTE, 8'(8'h30 + $urandom_range(0, 9)));
    send_text(" let");
    put_word(FUNC_END, 8'($urandom_range(0, 255)));

    items = 0;
    while (items < 1350) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 20)) put_word(FUNC_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 30)) send_token();
      end
      put_word(FUNC_END, 8'($urandom_range(0, 255)));
    end

    src_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("[keyword_token_lexer] OK");
    end else begin
      $display("[keyword_token_lexer] ERROR");
    end
    $finish;
  end

  initial begin
    #300_000_000;
    $display("[keyword_token_lexer] ERROR");
    $finish;
  end

endmodule

>>> keyword_token_lexer.f
rtl/ktl_pkg.sv
rtl/ktl_src_if.sv
rtl/ktl_tok_if.sv
rtl/ktl_tok_queue.sv
rtl/keyword_token_lexer.sv
dv/token_stream_checker.sv
dv/tb_keyword_token_lexer.sv
